[rtl/lif_neuron_update_defines.svh]
// ----------------------------------------------------------------------------
// LIF neuron update: assertion macros
// Shared property macros for the block's concurrent checks. They sample on
// clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIF_NEURON_UPDATE_DEFINES_SVH
`define LIF_NEURON_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define LIF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lif_neuron_update: same-cycle check failed");

// Next-cycle implication.
`define LIF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lif_neuron_update: next-cycle check failed");

`endif

[rtl/lif_pkg.sv]
// ----------------------------------------------------------------------------
// LIF neuron update package
// Types, register and mode codes, the neuron record layout and shared
// arithmetic helpers.
// ----------------------------------------------------------------------------
package lif_pkg;

	localparam int NEURON_W   = 10;
	localparam int NRN_MAX    = 1 << NEURON_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RESTING   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_DECAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYN_DECAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NPL       = 3'd5;

	// Command modes.
	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_INJECT = 2'd1;
	localparam logic [1:0] MODE_THRESH = 2'd2;

	// Layer divider: quotient bits resolved per cycle.
	localparam int DIV_STEPS = 5;
	localparam int DIV_ITERS = NEURON_W / DIV_STEPS;
	localparam int DIV_CNT_W = 2;

	typedef struct packed {
		logic signed [31:0] membrane;
		logic signed [31:0] syn;
		logic signed [31:0] thresh;
		logic [31:0]        last_fire;
		logic               refr;
		logic [31:0]        count;
	} nrn_word_t;

	localparam nrn_word_t NRN_RESET = '{
		membrane:  32'sd0,
		syn:       32'sd0,
		thresh:    32'sd65536,
		last_fire: 32'd0,
		refr:      1'b0,
		count:     32'd0
	};

	typedef struct packed {
		logic [10:0]         rem;
		logic [NEURON_W-1:0] quo;
	} div_state_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic fin;
		logic clr;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [38:0] x);
		logic signed [31:0] r;
		if (x > 39'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -39'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Restoring division, DIV_STEPS quotient bits per call.
	function automatic div_state_t div_steps(input div_state_t s, input logic [10:0] dv);
		div_state_t r;
		logic [11:0] t;
		r = s;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.quo[NEURON_W-1]};
			r.quo = {r.quo[NEURON_W-2:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				t = t - {1'b0, dv};
				r.quo[0] = 1'b1;
			end
			r.rem = t[10:0];
		end
		return r;
	endfunction

endpackage

[rtl/lif_ram.sv]
// ----------------------------------------------------------------------------
// LIF generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lif_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/lif_div.sv]
// ----------------------------------------------------------------------------
// LIF layer divider
// Multi-cycle restoring divider giving neuron index / neurons per layer.
// ----------------------------------------------------------------------------
module lif_div import lif_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NEURON_W-1:0] dividend,
	input  logic [10:0]         divisor,
	output logic [NEURON_W-1:0] quotient,
	output logic                done
);

	div_state_t           st_q;
	div_state_t           step_in;
	div_state_t           step_out;
	logic [DIV_CNT_W-1:0] cnt_q;

	// The first group of quotient bits is resolved in the start cycle.
	always_comb begin
		if (start) begin
			step_in = '{rem: '0, quo: dividend};
		end else begin
			step_in = st_q;
		end
		step_out = div_steps(step_in, divisor);
	end

	always_ff @(posedge clk) begin
		if (start || (cnt_q != '0)) begin
			st_q <= step_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_ITERS - 1);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient = st_q.quo;
	assign done     = (cnt_q == '0);

endmodule

[rtl/lif_ctrl.sv]
// ----------------------------------------------------------------------------
// LIF controller
// Sequences the store clear, the read, multiply and write-back steps of one
// item, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module lif_ctrl import lif_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_MUL   = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign cmd.mul    = (state_q == S_MUL);
	assign cmd.fin    = (state_q == S_FIN) && sts.div_done && out_free;
	assign cmd.clr    = (state_q == S_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (cmd.fin) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/lif_dp.sv]
// ----------------------------------------------------------------------------
// LIF datapath
// Configuration registers, the neuron store, the membrane and synaptic
// arithmetic, the layer divider and the result register.
// ----------------------------------------------------------------------------
module lif_dp import lif_pkg::*; #(
	parameter int STORE_NEURONS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_sts_t                sts,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [1:0]             mode,
	input  logic [NEURON_W-1:0]    neuron,
	input  logic [31:0]            time_now,
	input  logic signed [31:0]     operand_value,
	output logic                   spiked,
	output logic [NEURON_W-1:0]    neuron_out,
	output logic [NEURON_W-1:0]    layer_out,
	output logic signed [31:0]     potential_out,
	output logic [31:0]            spike_total,
	output logic                   held_refractory
);

	localparam int DEPTH = (STORE_NEURONS < NRN_MAX) ? STORE_NEURONS : NRN_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [16:0] NUM_LIM = 17'(STORE_NEURONS);

	// Configuration.
	logic signed [23:0] rest_q;
	logic [15:0]        mdec_q;
	logic [19:0]        gain_q;
	logic [15:0]        sdec_q;
	logic [7:0]         rticks_q;
	logic [10:0]        npl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q   <= -24'sd4587520;
			mdec_q   <= 16'd62339;
			gain_q   <= 20'd31966;
			sdec_q   <= 16'd53656;
			rticks_q <= 8'd2;
			npl_q    <= 11'd1024;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RESTING:   rest_q   <= cfg_wdata;
				REG_MEM_DECAY: mdec_q   <= cfg_wdata[15:0];
				REG_GAIN:      gain_q   <= cfg_wdata[19:0];
				REG_SYN_DECAY: sdec_q   <= cfg_wdata[15:0];
				REG_REFRACT:   rticks_q <= cfg_wdata[7:0];
				REG_NPL:       npl_q    <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// Item registers.
	logic [1:0]          mode_q;
	logic [NEURON_W-1:0] neuron_q;
	logic [31:0]         time_q;
	logic signed [31:0]  opv_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= mode;
			neuron_q <= neuron;
			time_q   <= time_now;
			opv_q    <= operand_value;
			hit_q    <= ({7'd0, neuron} < NUM_LIM);
		end
	end

	// Clear sweep address.
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Neuron store.
	nrn_word_t                    old_w;
	nrn_word_t                    new_w;
	logic [$bits(nrn_word_t)-1:0] rd_data;
	logic [$bits(nrn_word_t)-1:0] wr_data;
	logic [AW-1:0]                wr_addr;
	logic                         wr_en;

	assign wr_en   = cmd.clr || (cmd.fin && hit_q);
	assign wr_addr = cmd.clr ? clr_addr_q : neuron_q[AW-1:0];
	assign wr_data = cmd.clr ? NRN_RESET : new_w;
	assign old_w   = nrn_word_t'(rd_data);

	lif_ram #(
		.WIDTH ($bits(nrn_word_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.accept),
		.raddr (neuron[AW-1:0]),
		.rdata (rd_data)
	);

	// Layer divider.
	logic [10:0]         div_dv;
	logic [NEURON_W-1:0] layer_out_d;
	logic                div_done;

	assign div_dv = (npl_q == '0) ? 11'd1 : npl_q;

	lif_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.dividend (neuron),
		.divisor  (div_dv),
		.quotient (layer_out_d),
		.done     (div_done)
	);

	assign sts = '{clr_last: (clr_addr_q == AW'(DEPTH - 1)), div_done: div_done};

	// Multiply stage: store data is valid in the cycle after the read.
	logic signed [32:0] diff;
	logic signed [49:0] p_mem;
	logic signed [52:0] p_in;
	logic signed [48:0] p_sd;
	logic [31:0]        elapsed;
	logic               run;
	logic signed [49:0] p_mem_s1;
	logic signed [52:0] p_in_s1;
	logic signed [48:0] p_sd_s1;
	logic               run_s1;

	assign diff    = {old_w.membrane[31], old_w.membrane} - {{9{rest_q[23]}}, rest_q};
	assign p_mem   = diff * $signed({1'b0, mdec_q});
	assign p_in    = old_w.syn * $signed({1'b0, gain_q});
	assign p_sd    = old_w.syn * $signed({1'b0, sdec_q});
	assign elapsed = time_q - old_w.last_fire;
	assign run     = !old_w.refr || (elapsed > {24'd0, rticks_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_mem_s1 <= p_mem;
			p_in_s1  <= p_in;
			p_sd_s1  <= p_sd;
			run_s1   <= run;
		end
	end

	// Write-back stage. The rest term carries the rounding half in its low bits.
	logic signed [54:0] rest_term;
	logic signed [54:0] acc;
	logic signed [48:0] sd_rnd;
	logic signed [32:0] syn_sum;
	logic signed [31:0] v_new;
	logic signed [31:0] syn_dec;
	logic signed [31:0] syn_add;
	logic signed [31:0] rest_32;
	logic               spk;
	logic               held;

	assign rest_term = {{15{rest_q[23]}}, rest_q, 16'h8000};
	assign acc       = rest_term + 55'(p_mem_s1) + 55'(p_in_s1);
	assign v_new     = sat32(acc[54:16]);
	assign sd_rnd    = p_sd_s1 + 49'sd32768;
	assign syn_dec   = sat32(39'($signed(sd_rnd[48:16])));
	assign syn_sum   = {old_w.syn[31], old_w.syn} + {opv_q[31], opv_q};
	assign syn_add   = sat32(39'(syn_sum));
	assign rest_32   = 32'(rest_q);

	always_comb begin
		new_w = old_w;
		spk   = 1'b0;
		held  = 1'b0;
		case (mode_q)
			MODE_UPDATE: begin
				if (run_s1) begin
					new_w.syn  = syn_dec;
					new_w.refr = 1'b0;
					if (v_new >= old_w.thresh) begin
						if (old_w.count != 32'hffffffff) begin
							new_w.count = old_w.count + 32'd1;
						end
						new_w.last_fire = time_q;
						new_w.refr      = 1'b1;
						new_w.membrane  = rest_32;
						spk             = 1'b1;
					end else begin
						new_w.membrane = v_new;
					end
				end else begin
					held = 1'b1;
				end
			end
			MODE_INJECT: begin
				new_w.syn = syn_add;
			end
			MODE_THRESH: begin
				new_w.thresh = opv_q;
			end
			default: ;
		endcase
	end

	// Result register.
	logic                spiked_q;
	logic [NEURON_W-1:0] neuron_out_q;
	logic [NEURON_W-1:0] layer_out_q;
	logic signed [31:0]  potential_q;
	logic [31:0]         total_q;
	logic                held_q;

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			spiked_q     <= hit_q && spk;
			neuron_out_q <= neuron_q;
			layer_out_q  <= layer_out_d;
			potential_q  <= hit_q ? new_w.membrane : 32'sd0;
			total_q      <= hit_q ? new_w.count : 32'd0;
			held_q       <= hit_q && held;
		end
	end

	assign spiked          = spiked_q;
	assign neuron_out      = neuron_out_q;
	assign layer_out       = layer_out_q;
	assign potential_out   = potential_q;
	assign spike_total     = total_q;
	assign held_refractory = held_q;

endmodule

[rtl/lif_neuron_update.sv]
// ----------------------------------------------------------------------------
// LIF neuron update
// Store of leaky integrate-and-fire neurons serving one command per beat:
// update a neuron, inject synaptic input, or load a threshold.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries mode, neuron, time_now and
// operand_value; the output channel (out_valid / out_stall) returns exactly
// one result beat per input beat, in order.
// After reset the neuron store is swept to its reset contents, one entry per
// cycle over min(STORE_NEURONS, 1024) entries; in_stall stays high meanwhile.
// Configuration writes are taken at any time, but are meant for idle periods.
// An item runs through the accept, multiply and write-back states: the accept
// cycle issues the store read, the multiply state runs the three multipliers,
// and write-back writes the neuron back and loads the result register and
// out_valid. The store's single read-modify-write keeps items apart, so the
// block takes no new item until the last one is written back.
// When the receiver stalls, the result is held; the block still accepts the
// next item and runs it up to write-back, where it waits for the result
// register to free up.
// ----------------------------------------------------------------------------
`include "lif_neuron_update_defines.svh"

module lif_neuron_update import lif_pkg::*; #(
	parameter int STORE_NEURONS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [NEURON_W-1:0]   neuron,
	input  logic [31:0]           time_now,
	input  logic signed [31:0]    operand_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  spiked,
	output logic [NEURON_W-1:0]   neuron_out,
	output logic [NEURON_W-1:0]   layer_out,
	output logic signed [31:0]    potential_out,
	output logic [31:0]           spike_total,
	output logic                  held_refractory
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	lif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lif_dp #(
		.STORE_NEURONS (STORE_NEURONS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mode            (mode),
		.neuron          (neuron),
		.time_now        (time_now),
		.operand_value   (operand_value),
		.spiked          (spiked),
		.neuron_out      (neuron_out),
		.layer_out       (layer_out),
		.potential_out   (potential_out),
		.spike_total     (spike_total),
		.held_refractory (held_refractory)
	);

	// An accepted beat always moves into the multiply step next.
	`LIF_ASSERT_NXT(a_accept_then_mul, in_valid && !in_stall, cmd.mul)
	// The multiply step is always followed by the write-back state's first cycle.
	`LIF_ASSERT_NXT(a_mul_then_busy, cmd.mul, in_stall && !cmd.mul)
	// A write-back always presents a result in the following cycle.
	`LIF_ASSERT_NXT(a_fin_then_out, cmd.fin, out_valid)
	// The layer quotient is complete whenever the write-back state is reached.
	`LIF_ASSERT_NXT(a_div_ready, cmd.mul, sts.div_done)

endmodule

[dv/tb_lif_neuron_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron update testbench
// Drives update, inject, threshold and unused-mode commands into the neuron
// store under four register settings with random idling on both channels,
// and checks every result beat against a cycle-free model of the neuron store.
// ----------------------------------------------------------------------------
module tb_lif_neuron_update;
	import lif_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct packed {
		logic [1:0]          mode;
		logic [NEURON_W-1:0] neuron;
		logic [31:0]         tick;
		logic signed [31:0]  operand;
	} lif_cmd_t;

	typedef struct packed {
		logic                spiked;
		logic [NEURON_W-1:0] neuron;
		logic [NEURON_W-1:0] layer;
		logic signed [31:0]  potential;
		logic [31:0]         total;
		logic                held;
	} lif_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode = '0;
	logic [NEURON_W-1:0]   neuron = '0;
	logic [31:0]           time_now = '0;
	logic signed [31:0]    operand_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  spiked;
	logic [NEURON_W-1:0]   neuron_out;
	logic [NEURON_W-1:0]   layer_out;
	logic signed [31:0]    potential_out;
	logic [31:0]           spike_total;
	logic                  held_refractory;

	// Register copies, at their reset values.
	logic signed [23:0] cfg_rest = -24'sd4587520;
	logic [15:0]        cfg_mem_decay = 16'd62339;
	logic [19:0]        cfg_gain = 20'd31966;
	logic [15:0]        cfg_syn_decay = 16'd53656;
	logic [7:0]         cfg_refr = 8'd2;
	logic [10:0]        cfg_layer_size = 11'd1024;

	// Neuron store copy.
	logic signed [31:0] nrn_membrane [NRN_MAX];
	logic signed [31:0] nrn_syn [NRN_MAX];
	logic signed [31:0] nrn_thresh [NRN_MAX];
	logic [31:0]        nrn_last_fire [NRN_MAX];
	logic               nrn_refr [NRN_MAX];
	logic [31:0]        nrn_count [NRN_MAX];

	lif_cmd_t    cmd_backlog[$];
	lif_result_t pending_results[$];
	lif_cmd_t    offered_cmd;

	int          send_idle_pct = 7;
	int          stall_pct = 80;
	logic        holdoff_req = 1'b0;
	logic        holdoff_done = 1'b0;
	int          holdoff_left = 0;
	int          error_count = 0;
	logic [31:0] tick_now = '0;
	logic [NEURON_W-1:0] neuron_pool [8];

	lif_neuron_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.neuron(neuron),
		.time_now(time_now),
		.operand_value(operand_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spiked(spiked),
		.neuron_out(neuron_out),
		.layer_out(layer_out),
		.potential_out(potential_out),
		.spike_total(spike_total),
		.held_refractory(held_refractory)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp_q16(input longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Applies one command to the store copy and returns the result it yields.
	function automatic lif_result_t advance_neuron(input lif_cmd_t c);
		lif_result_t r;
		logic [10:0] layer_div;
		logic [10:0] layer_q;
		logic [31:0] elapsed;
		logic signed [31:0] v;
		logic run;
		longint rest, acc, memv, synv, mdk, gk, sdk, opk;
		int unsigned n;
		n = c.neuron;
		r = '0;
		r.neuron = c.neuron;
		layer_div = (cfg_layer_size == 11'd0) ? 11'd1 : cfg_layer_size;
		layer_q = {1'b0, c.neuron} / layer_div;
		r.layer = layer_q[NEURON_W-1:0];
		rest = cfg_rest;
		memv = nrn_membrane[n];
		synv = nrn_syn[n];
		mdk = cfg_mem_decay;
		gk = cfg_gain;
		sdk = cfg_syn_decay;
		opk = c.operand;
		case (c.mode)
		MODE_UPDATE: begin
			run = 1'b1;
			if (nrn_refr[n]) begin
				// Wrapping difference, so time running backwards looks long.
				elapsed = c.tick - nrn_last_fire[n];
				if (elapsed > cfg_refr) begin
					nrn_refr[n] = 1'b0;
				end else begin
					run = 1'b0;
				end
			end
			if (run) begin
				acc = rest * 65536 + (memv - rest) * mdk + synv * gk;
				v = clamp_q16((acc + 64'sd32768) >>> 16);
				nrn_syn[n] = clamp_q16((synv * sdk + 64'sd32768) >>> 16);
				if (v >= nrn_thresh[n]) begin
					if (nrn_count[n] != '1) begin
						nrn_count[n] = nrn_count[n] + 1;
					end
					nrn_last_fire[n] = c.tick;
					nrn_refr[n] = 1'b1;
					v = cfg_rest;
					r.spiked = 1'b1;
				end
				nrn_membrane[n] = v;
			end else begin
				r.held = 1'b1;
			end
		end
		MODE_INJECT: begin
			nrn_syn[n] = clamp_q16(synv + opk);
		end
		MODE_THRESH: begin
			nrn_thresh[n] = c.operand;
		end
		default: begin
		end
		endcase
		r.potential = nrn_membrane[n];
		r.total = nrn_count[n];
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, what, want, got);
			error_count++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_RESTING:   cfg_rest = val[23:0];
		REG_MEM_DECAY: cfg_mem_decay = val[15:0];
		REG_GAIN:      cfg_gain = val[19:0];
		REG_SYN_DECAY: cfg_syn_decay = val[15:0];
		REG_REFRACT:   cfg_refr = val[7:0];
		REG_NPL:       cfg_layer_size = val[10:0];
		default: begin
		end
		endcase
	endtask

	task automatic apply_settings(input logic [23:0] rest, input logic [15:0] md,
			input logic [19:0] gain, input logic [15:0] sd, input logic [7:0] refr,
			input logic [10:0] npl);
		write_reg(REG_RESTING, rest);
		write_reg(REG_MEM_DECAY, md);
		write_reg(REG_GAIN, gain);
		write_reg(REG_SYN_DECAY, sd);
		write_reg(REG_REFRACT, refr);
		write_reg(REG_NPL, npl);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_cmd(input logic [1:0] m, input logic [NEURON_W-1:0] n,
			input logic [31:0] t, input logic signed [31:0] opv);
		lif_cmd_t c;
		c.mode = m;
		c.neuron = n;
		c.tick = t;
		c.operand = opv;
		cmd_backlog.push_back(c);
	endtask

	// Mostly traffic on a few neurons so that state builds up and spikes
	// happen; thresholds are placed near the resting potential.
	task automatic queue_random(input int count);
		lif_cmd_t c;
		int unsigned pick;
		logic [31:0] mag;
		logic signed [31:0] rest32;
		rest32 = cfg_rest;
		for (int k = 0; k < 8; k++) begin
			neuron_pool[k] = NEURON_W'($urandom_range(0, NRN_MAX - 1));
		end
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				c.mode = MODE_UPDATE;
			end else if (pick < 78) begin
				c.mode = MODE_INJECT;
			end else if (pick < 94) begin
				c.mode = MODE_THRESH;
			end else begin
				c.mode = MODE_UNUSED;
			end
			if ($urandom_range(0, 99) < 85) begin
				c.neuron = neuron_pool[$urandom_range(0, 7)];
			end else begin
				c.neuron = NEURON_W'($urandom_range(0, NRN_MAX - 1));
			end
			c.tick = $urandom();
			c.operand = $urandom();
			if (c.mode == MODE_UPDATE && $urandom_range(0, 19) != 0) begin
				tick_now = tick_now + $urandom_range(0, 3);
				c.tick = tick_now;
			end
			if (c.mode == MODE_INJECT && $urandom_range(0, 9) != 0) begin
				mag = $urandom_range(0, 20 * 65536);
				c.operand = ($urandom_range(0, 4) == 0) ? -mag : mag;
			end
			if (c.mode == MODE_THRESH && $urandom_range(0, 6) != 0) begin
				c.operand = rest32 + $urandom_range(0, 88 * 65536) - 8 * 65536;
			end
			cmd_backlog.push_back(c);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Command driver: a new beat is offered only once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				pending_results.push_back(advance_neuron(offered_cmd));
			end
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				offered_cmd = cmd_backlog.pop_front();
				mode <= offered_cmd.mode;
				neuron <= offered_cmd.neuron;
				time_now <= offered_cmd.tick;
				operand_value <= offered_cmd.operand;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_req && !holdoff_done) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		lif_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, neuron 0x%h",
						$time, neuron_out);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("spiked", want.spiked, spiked);
					check_field("neuron_out", want.neuron, neuron_out);
					check_field("layer_out", want.layer, layer_out);
					check_field("potential_out", want.potential, potential_out);
					check_field("spike_total", want.total, spike_total);
					check_field("held_refractory", want.held, held_refractory);
				end
			end
			out_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin
		#3_000_000;
		$display("lif_neuron_update verification failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < NRN_MAX; i++) begin
			nrn_membrane[i] = '0;
			nrn_syn[i] = '0;
			nrn_thresh[i] = 32'sd65536;
			nrn_last_fire[i] = '0;
			nrn_refr[i] = 1'b0;
			nrn_count[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default settings, then the corner cases of the command set.
		apply_settings(-24'sd4587520, 16'd62339, 20'd31966, 16'd53656, 8'd2, 11'd1024);
		queue_cmd(MODE_UNUSED, 10'd0, 32'd0, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd0, 32'd0, 32'sd0);
		// Lowest threshold: fires on every run, so refractory handling shows.
		queue_cmd(MODE_THRESH, 10'd1023, 32'd0, 32'sh80000000);
		queue_cmd(MODE_UPDATE, 10'd1023, 32'd10, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd1023, 32'd11, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd1023, 32'd12, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd1023, 32'd13, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd1023, 32'd5, 32'sd0);
		queue_cmd(MODE_INJECT, 10'd5, 32'd0, 32'sh7fffffff);
		queue_cmd(MODE_INJECT, 10'd5, 32'd0, 32'sh7fffffff);
		queue_cmd(MODE_UPDATE, 10'd5, 32'd20, 32'sd0);
		queue_cmd(MODE_INJECT, 10'd6, 32'd0, 32'sh80000000);
		queue_cmd(MODE_INJECT, 10'd6, 32'd0, 32'sh80000000);
		queue_cmd(MODE_UPDATE, 10'd6, 32'd20, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd6, 32'd21, 32'sd0);
		queue_cmd(MODE_THRESH, 10'd2, 32'd0, 32'sh7fffffff);
		queue_cmd(MODE_INJECT, 10'd2, 32'd0, 32'sh7fffffff);
		queue_cmd(MODE_UPDATE, 10'd2, 32'd30, 32'sd0);
		queue_cmd(MODE_INJECT, 10'd3, 32'd0, 32'sh00050000);
		queue_cmd(MODE_THRESH, 10'd3, 32'd0, -32'sd3932160);
		queue_cmd(MODE_UPDATE, 10'd3, 32'd40, 32'sd0);
		queue_cmd(MODE_UPDATE, 10'd3, 32'd41, 32'sd0);
		queue_cmd(MODE_UNUSED, 10'd1023, 32'hffffffff, 32'shffffffff);
		queue_cmd(MODE_UPDATE, 10'd512, 32'hffffffff, 32'sd0);
		tick_now = 32'd100;
		queue_random(400);
		wait_drained();

		// Low rest, full decay and gain, longest refractory, one neuron per layer.
		apply_settings(24'h800000, 16'hffff, 20'hfffff, 16'hffff, 8'd255, 11'd1);
		queue_random(400);
		wait_drained();

		// High rest, no decay or gain, no refractory wait, zero layer size.
		send_idle_pct = 80;
		stall_pct = 7;
		apply_settings(24'h7fffff, 16'd0, 20'd0, 16'd0, 8'd0, 11'd0);
		tick_now = 32'hffffff00;
		queue_random(400);
		wait_drained();

		send_idle_pct = 0;
		stall_pct = 0;
		apply_settings(24'($urandom_range(0, 200 * 65536) - 100 * 65536),
			16'($urandom()), 20'($urandom()), 16'($urandom()),
			8'($urandom_range(0, 8)), 11'($urandom_range(1, 1024)));
		queue_random(450);
		holdoff_req = 1'b1;
		wait_drained();

		repeat (20) @(negedge clk);
		if (error_count == 0) begin
			$display("lif_neuron_update verification clean");
		end else begin
			$display("lif_neuron_update verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/lif_pkg.sv
rtl/lif_ram.sv
rtl/lif_div.sv
rtl/lif_ctrl.sv
rtl/lif_dp.sv
rtl/lif_neuron_update.sv
dv/tb_lif_neuron_update.sv
